### src/glyph_outline_3x3_macros.svh
// Assertion macros for the glyph outline RTL.
`ifndef GLYPH_OUTLINE_3X3_MACROS_SVH
`define GLYPH_OUTLINE_3X3_MACROS_SVH
`ifndef SYNTH
`define GO_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("%m: check failed");
`define GO_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("%m: check failed");
`else
`define GO_ASSERT(lbl, prop)
`define GO_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

### src/gol_pkg.sv
// Types and constants of the glyph outline block.
package gol_pkg;

	localparam int MAX_HEIGHT = 1024;
	localparam int HW = 11;
	localparam int CFG_W = 11;
	localparam int CFG_IDX_W = 1;

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

	localparam logic [6:0] WIDTH_RESET = 7'd16;
	localparam logic [HW-1:0] HEIGHT_RESET = 11'd16;

	localparam logic [7:0] PIX_CLEAR = 8'd0;
	localparam logic [7:0] PIX_OUTLINE = 8'd15;
	localparam logic [7:0] PIX_INTERIOR = 8'd255;

	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_PTR_W = 2;
	localparam int QUEUE_CNT_W = 3;

	// One stream slot handed from the front to the back.
	typedef struct packed {
		logic flag;
		logic emit;
		logic last;
		logic top_ok;
		logic bot_ok;
		logic left_ok;
		logic right_ok;
	} slot_t;

endpackage

### src/gol_front.sv
// Front end: config registers, item classification and frame position tracking.
module gol_front #(
	parameter int MAX_WIDTH = 64,
	parameter int WW = $clog2(MAX_WIDTH + 1)
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [gol_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [gol_pkg::CFG_W-1:0]    cfg_data,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [7:0]                   s_tdata,
	input  logic                         s_tuser,
	input  logic                         q_full,
	output logic                         q_wr,
	output gol_pkg::slot_t               q_slot,
	output logic [WW-1:0]                eff_w
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int PW = $clog2(MAX_WIDTH + 2);

	logic [6:0]             width_q;
	logic [gol_pkg::HW-1:0] height_q;
	logic [gol_pkg::HW-1:0] eff_h;
	logic [CW-1:0]          col_q;
	logic [gol_pkg::HW-1:0] row_q;
	logic [PW-1:0]          pre_q;
	logic [CW-1:0]          out_col_q;
	logic [gol_pkg::HW-1:0] out_row_q;
	logic                   accept;
	logic                   frame_full;
	logic                   push;
	logic                   emit;
	logic                   col_wrap;
	logic                   out_col_wrap;
	logic                   last;
	logic                   restart;

	always_comb begin
		if (width_q == 7'd0) begin
			eff_w = WW'(1);
		end else if (32'(width_q) > MAX_WIDTH) begin
			eff_w = WW'(MAX_WIDTH);
		end else begin
			eff_w = WW'(width_q);
		end
		if (height_q == '0) begin
			eff_h = gol_pkg::HW'(1);
		end else if (32'(height_q) > gol_pkg::MAX_HEIGHT) begin
			eff_h = gol_pkg::HW'(gol_pkg::MAX_HEIGHT);
		end else begin
			eff_h = height_q;
		end
	end

	assign s_tready = !q_full;
	assign accept = s_tvalid && s_tready;
	assign frame_full = row_q >= eff_h;
	assign push = !frame_full && !s_tuser;
	// a drain before the frame is complete makes no slot
	assign q_wr = accept && (frame_full || !s_tuser);

	assign emit = pre_q == (PW'(eff_w) + PW'(1));
	assign col_wrap = (WW'(col_q) + WW'(1)) >= eff_w;
	assign out_col_wrap = (WW'(out_col_q) + WW'(1)) >= eff_w;
	assign last = emit && out_col_wrap && ((out_row_q + gol_pkg::HW'(1)) >= eff_h);
	assign restart = q_wr && last;

	always_comb begin
		q_slot.flag = push && (s_tdata != 8'd0);
		q_slot.emit = emit;
		q_slot.last = last;
		q_slot.top_ok = out_row_q != '0;
		q_slot.bot_ok = (out_row_q + gol_pkg::HW'(1)) < eff_h;
		q_slot.left_ok = out_col_q != '0;
		q_slot.right_ok = !out_col_wrap;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= gol_pkg::WIDTH_RESET;
			height_q <= gol_pkg::HEIGHT_RESET;
			col_q <= '0;
			row_q <= '0;
			pre_q <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				gol_pkg::REG_IMAGE_WIDTH: width_q <= cfg_data[6:0];
				gol_pkg::REG_IMAGE_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
			col_q <= '0;
			row_q <= '0;
			pre_q <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (restart) begin
			col_q <= '0;
			row_q <= '0;
			pre_q <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (q_wr) begin
			if (push) begin
				if (col_wrap) begin
					col_q <= '0;
					row_q <= row_q + gol_pkg::HW'(1);
				end else begin
					col_q <= col_q + CW'(1);
				end
			end
			if (!emit) begin
				pre_q <= pre_q + PW'(1);
			end else if (out_col_wrap) begin
				out_col_q <= '0;
				out_row_q <= out_row_q + gol_pkg::HW'(1);
			end else begin
				out_col_q <= out_col_q + CW'(1);
			end
		end
	end

endmodule

### src/gol_fifo.sv
// Short slot queue between the front and the back end.
`include "glyph_outline_3x3_macros.svh"

module gol_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_en,
	input  gol_pkg::slot_t wr_slot,
	output logic           full,
	input  logic           rd_en,
	output logic           empty,
	output gol_pkg::slot_t rd_slot
);

	gol_pkg::slot_t                   mem_q [gol_pkg::QUEUE_DEPTH];
	logic [gol_pkg::QUEUE_PTR_W-1:0]  wr_ptr_q;
	logic [gol_pkg::QUEUE_PTR_W-1:0]  rd_ptr_q;
	logic [gol_pkg::QUEUE_CNT_W-1:0]  cnt_q;
	logic                             do_wr;
	logic                             do_rd;

	assign full = cnt_q == gol_pkg::QUEUE_CNT_W'(gol_pkg::QUEUE_DEPTH);
	assign empty = cnt_q == '0;
	assign do_wr = wr_en && !full;
	assign do_rd = rd_en && !empty;
	assign rd_slot = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_slot;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == gol_pkg::QUEUE_PTR_W'(gol_pkg::QUEUE_DEPTH - 1)) ?
					'0 : wr_ptr_q + gol_pkg::QUEUE_PTR_W'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == gol_pkg::QUEUE_PTR_W'(gol_pkg::QUEUE_DEPTH - 1)) ?
					'0 : rd_ptr_q + gol_pkg::QUEUE_PTR_W'(1);
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + gol_pkg::QUEUE_CNT_W'(1);
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - gol_pkg::QUEUE_CNT_W'(1);
			end
		end
	end

	`GO_ASSERT(a_cnt_bound, cnt_q <= gol_pkg::QUEUE_CNT_W'(gol_pkg::QUEUE_DEPTH))
	`GO_ASSERT(a_no_wr_full, !(wr_en && full))
	`GO_ASSERT(a_no_rd_empty, !(rd_en && empty))
	`GO_ASSERT_NEXT(a_cnt_up, do_wr && !do_rd, cnt_q == $past(cnt_q) + gol_pkg::QUEUE_CNT_W'(1))

endmodule

### src/gol_back.sv
// Back end: line delays, 3x3 window and classified output register.
module gol_back #(
	parameter int MAX_WIDTH = 64,
	parameter int WW = $clog2(MAX_WIDTH + 1)
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic [WW-1:0]  eff_w,
	input  logic           q_empty,
	input  gol_pkg::slot_t q_slot,
	output logic           q_rd,
	output logic           m_tvalid,
	input  logic           m_tready,
	output logic [7:0]     m_tdata,
	output logic           m_tlast
);

	// line delays of exactly eff_w slots: entry 0 is the oldest
	logic [MAX_WIDTH-1:0] line1_q;
	logic [MAX_WIDTH-1:0] line2_q;
	// window rows, bit 0 is the newest slot of the row (right neighbor)
	logic [2:0]           bot_q;
	logic [2:0]           mid_q;
	logic [2:0]           top_q;
	logic [2:0]           bot_n;
	logic [2:0]           mid_n;
	logic [2:0]           top_n;
	logic [8:0]           win;
	logic                 out_vld_q;
	logic [7:0]           out_pix_q;
	logic                 out_last_q;
	logic [7:0]           pix_n;

	assign q_rd = !q_empty && (!q_slot.emit || !out_vld_q || m_tready);

	assign bot_n = {bot_q[1:0], q_slot.flag};
	assign mid_n = {mid_q[1:0], line1_q[0]};
	assign top_n = {top_q[1:0], line2_q[0]};

	always_comb begin
		win[0] = top_n[2] && q_slot.top_ok && q_slot.left_ok;
		win[1] = top_n[1] && q_slot.top_ok;
		win[2] = top_n[0] && q_slot.top_ok && q_slot.right_ok;
		win[3] = mid_n[2] && q_slot.left_ok;
		win[4] = mid_n[1];
		win[5] = mid_n[0] && q_slot.right_ok;
		win[6] = bot_n[2] && q_slot.bot_ok && q_slot.left_ok;
		win[7] = bot_n[1] && q_slot.bot_ok;
		win[8] = bot_n[0] && q_slot.bot_ok && q_slot.right_ok;
		if (!win[4]) begin
			pix_n = gol_pkg::PIX_CLEAR;
		end else if (&win) begin
			pix_n = gol_pkg::PIX_INTERIOR;
		end else begin
			pix_n = gol_pkg::PIX_OUTLINE;
		end
	end

	always_ff @(posedge clk) begin
		if (q_rd) begin
			for (int k = 0; k < MAX_WIDTH - 1; k++) begin
				if (WW'(k) == eff_w - WW'(1)) begin
					line1_q[k] <= q_slot.flag;
					line2_q[k] <= line1_q[0];
				end else begin
					line1_q[k] <= line1_q[k+1];
					line2_q[k] <= line2_q[k+1];
				end
			end
			line1_q[MAX_WIDTH-1] <= q_slot.flag;
			line2_q[MAX_WIDTH-1] <= line1_q[0];
			bot_q <= bot_n;
			mid_q <= mid_n;
			top_q <= top_n;
		end
		if (q_rd && q_slot.emit) begin
			out_pix_q <= pix_n;
			out_last_q <= q_slot.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (q_rd && q_slot.emit) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata = out_pix_q;
	assign m_tlast = out_last_q;

endmodule

### src/glyph_outline_3x3.sv
// Top level of the 3x3 glyph outline classifier.
// Takes one pixel or drain transaction per cycle while s_tready is high and returns each
// pixel's class (0 clear, 15 outline, 255 interior) image_width+1 slots later; after a
// frame's last pixel, drain transactions flush the remaining image_width+1 results, and the
// result of the final pixel carries tlast and restarts the frame. Sustained rate is one
// transaction per cycle while the receiver takes results: the front classifies and counts
// positions, a four-entry queue decouples it from the back, and the back shifts two
// flip-flop line delays and the window once per slot, stalling only while its output
// register holds an untaken result. A configuration write restarts the frame.
module glyph_outline_3x3 #(
	parameter int MAX_WIDTH = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [gol_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [gol_pkg::CFG_W-1:0]     cfg_data,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [7:0]                    s_tdata,  // [7:0] pixel
	input  logic                          s_tuser,  // [0] action
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [7:0]                    m_tdata,  // [7:0] out_pixel
	output logic                          m_tlast
);

	localparam int WW = $clog2(MAX_WIDTH + 1);

	logic [WW-1:0]  eff_w;
	logic           q_full;
	logic           q_empty;
	logic           q_wr;
	logic           q_rd;
	gol_pkg::slot_t wr_slot;
	gol_pkg::slot_t rd_slot;

	gol_front #(
		.MAX_WIDTH(MAX_WIDTH),
		.WW(WW)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.q_full(q_full),
		.q_wr(q_wr),
		.q_slot(wr_slot),
		.eff_w(eff_w)
	);

	gol_fifo u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(q_wr),
		.wr_slot(wr_slot),
		.full(q_full),
		.rd_en(q_rd),
		.empty(q_empty),
		.rd_slot(rd_slot)
	);

	gol_back #(
		.MAX_WIDTH(MAX_WIDTH),
		.WW(WW)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.eff_w(eff_w),
		.q_empty(q_empty),
		.q_slot(rd_slot),
		.q_rd(q_rd),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast)
	);

endmodule

### test/glyph_outline_3x3_checker.sv
`timescale 1ns / 100ps
// Checker for the glyph outline classifier: tracks registers, predicts pixel classes, compares.
package gol_tb_pkg;

	localparam logic ACT_PUSH = 1'b0;
	localparam logic ACT_DRAIN = 1'b1;

endpackage

module glyph_outline_3x3_checker #(
	parameter int MAX_WIDTH = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [gol_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [gol_pkg::CFG_W-1:0]     cfg_data,
	input  logic                          s_tvalid,
	input  logic                          s_tready,
	input  logic [7:0]                    s_tdata,  // [7:0] pixel
	input  logic                          s_tuser,  // [0] action
	input  logic                          m_tvalid,
	input  logic                          m_tready,
	input  logic [7:0]                    m_tdata,  // [7:0] out_pixel
	input  logic                          m_tlast,
	output int                            errors,
	output int                            outstanding,
	output int                            checked
);
	import gol_pkg::*;
	import gol_tb_pkg::*;

	localparam int RING_LEN = 2 * MAX_WIDTH + 3;

	typedef struct packed {
		logic [7:0] pix;
		logic       last;
	} pixel_class_t;

	pixel_class_t class_q [$];
	bit           flag_ring [RING_LEN];
	logic [6:0]   width_reg;
	logic [HW-1:0] height_reg;
	int           ring_wr;
	int           slots;
	int           col_pos;
	int           row_pos;
	int           out_col;
	int           out_row;
	int           mismatches;
	int           results;

	function automatic int active_width();
		if (width_reg == 0) return 1;
		if (width_reg > MAX_WIDTH) return MAX_WIDTH;
		return int'(width_reg);
	endfunction

	function automatic int active_height();
		if (height_reg == 0) return 1;
		if (height_reg > MAX_HEIGHT) return MAX_HEIGHT;
		return int'(height_reg);
	endfunction

	function automatic void restart_frame();
		foreach (flag_ring[i]) flag_ring[i] = 1'b0;
		ring_wr = 0;
		slots = 0;
		col_pos = 0;
		row_pos = 0;
		out_col = 0;
		out_row = 0;
	endfunction

	// Shift one slot into the line history and, once the window is primed, classify its center.
	task automatic classify_slot(input bit drain, input logic [7:0] pix);
		int w;
		int h;
		int age;
		int idx;
		bit flag;
		logic [8:0] win;
		pixel_class_t res;
		w = active_width();
		h = active_height();
		flag = 1'b0;
		if (row_pos < h) begin
			// a drain before the frame is complete is dropped
			if (drain) return;
			flag = (pix != PIX_CLEAR);
			col_pos++;
			if (col_pos >= w) begin
				col_pos = 0;
				row_pos++;
			end
		end
		flag_ring[ring_wr] = flag;
		ring_wr = (ring_wr + 1) % RING_LEN;
		slots++;
		if (slots <= w + 1) return;

		win = '0;
		for (int dy = -1; dy <= 1; dy++) begin
			for (int dx = -1; dx <= 1; dx++) begin
				if (dy < 0 && out_row == 0) continue;
				if (dy > 0 && out_row + 1 >= h) continue;
				if (dx < 0 && out_col == 0) continue;
				if (dx > 0 && out_col + 1 >= w) continue;
				// center sits w+1 slots back; a row is w slots
				age = w + 1 - dy * w - dx;
				idx = (ring_wr + RING_LEN - 1 - age) % RING_LEN;
				win[(dy + 1) * 3 + dx + 1] = flag_ring[idx];
			end
		end

		if (!win[4]) res.pix = PIX_CLEAR;
		else if (&win) res.pix = PIX_INTERIOR;
		else res.pix = PIX_OUTLINE;

		out_col++;
		if (out_col >= w) begin
			out_col = 0;
			out_row++;
		end
		res.last = (out_row >= h);
		if (res.last) restart_frame();
		class_q.push_back(res);
	endtask

	always @(posedge clk) begin
		pixel_class_t want;
		if (!arst_n) begin
			width_reg = WIDTH_RESET;
			height_reg = HEIGHT_RESET;
			restart_frame();
			class_q.delete();
		end else begin
			// results first: a transaction accepted on this edge cannot show up yet
			if (m_tvalid && m_tready) begin
				results++;
				if (class_q.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual out_pixel=%0d tlast=%0b",
						$time, m_tdata, m_tlast);
					mismatches++;
				end else begin
					want = class_q.pop_front();
					if (m_tdata !== want.pix) begin
						$display("%0t: out_pixel expected %0d, actual %0d",
							$time, want.pix, m_tdata);
						mismatches++;
					end
					if (m_tlast !== want.last) begin
						$display("%0t: tlast expected %0b, actual %0b",
							$time, want.last, m_tlast);
						mismatches++;
					end
				end
			end
			if (cfg_we) begin
				if (cfg_index == REG_IMAGE_WIDTH) width_reg = cfg_data[6:0];
				else if (cfg_index == REG_IMAGE_HEIGHT) height_reg = cfg_data[HW-1:0];
				restart_frame();
			end
			if (s_tvalid && s_tready) classify_slot(s_tuser == ACT_DRAIN, s_tdata);
		end
		errors <= mismatches;
		outstanding <= class_q.size();
		checked <= results;
	end

endmodule

### test/glyph_outline_3x3_tb.sv
`timescale 1ns / 100ps
// Testbench top for the glyph outline classifier: clock, reset, stimulus and verdict.
module glyph_outline_3x3_tb;
	import gol_pkg::*;
	import gol_tb_pkg::*;

	localparam int MAX_WIDTH = 64;
	localparam int ITEM_TARGET = 1150;
	localparam int SETTLE_CYCLES = 16;
	localparam int HOLD_CYCLES = 500;
	localparam int CYCLE_LIMIT = 1000000;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = REG_IMAGE_WIDTH;
	logic [CFG_W-1:0]     cfg_data = '0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [7:0]           s_tdata = '0;
	logic                 s_tuser = ACT_PUSH;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [7:0]           m_tdata;
	logic                 m_tlast;

	int errors;
	int outstanding;
	int checked;
	int cycles = 0;
	int sent = 0;
	int counted = 0;
	int settings = 0;
	int cur_w = 16;
	int cur_h = 16;
	bit steady = 1'b0;
	bit squeeze_req = 1'b0;

	glyph_outline_3x3 #(
		.MAX_WIDTH(MAX_WIDTH)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast)
	);

	glyph_outline_3x3_checker #(
		.MAX_WIDTH(MAX_WIDTH)
	) i_chk (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast),
		.errors(errors),
		.outstanding(outstanding),
		.checked(checked)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("glyph_outline_3x3 verification failed");
			$finish;
		end
	end

	// Mostly short idle stretches, now and then a long one.
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 88) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [6:0] draw_width();
		case ($urandom_range(0, 9))
			0: return 7'd0;
			1: return 7'd64;
			2: return 7'($urandom_range(65, 127));
			3, 4: return 7'($urandom_range(9, 63));
			default: return 7'($urandom_range(1, 8));
		endcase
	endfunction

	function automatic logic [HW-1:0] draw_height();
		case ($urandom_range(0, 7))
			0: return 11'd0;
			1: return 11'd1;
			default: return 11'($urandom_range(2, 6));
		endcase
	endfunction

	task automatic send(input logic act, input logic [7:0] pix, input bit counts);
		int gap;
		gap = steady ? 0 : idle_len();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= act;
		s_tdata <= pix;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sent++;
		if (counts) counted++;
	endtask

	// Drain the result stream, then give the pipeline time to go quiet.
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic configure(input bit set_w, input logic [6:0] w7,
		input bit set_h, input logic [HW-1:0] h11);
		wait_idle();
		if (set_w) begin
			// upper data bits are junk the width register must drop
			cfg_we <= 1'b1;
			cfg_index <= REG_IMAGE_WIDTH;
			cfg_data <= {4'($urandom), w7};
			@(posedge clk);
			cur_w = (w7 == 0) ? 1 : (w7 > MAX_WIDTH) ? MAX_WIDTH : int'(w7);
		end
		if (set_h) begin
			cfg_we <= 1'b1;
			cfg_index <= REG_IMAGE_HEIGHT;
			cfg_data <= h11;
			@(posedge clk);
			cur_h = (h11 == 0) ? 1 : (h11 > MAX_HEIGHT) ? MAX_HEIGHT : int'(h11);
		end
		cfg_we <= 1'b0;
		settings++;
	endtask

	// One frame: pixels, then the drains that flush it. Noise adds early drains
	// and pushes past the end; a cut frame stops short and is never flushed.
	task automatic run_frame(input bit noisy, input bit cut, input bit counts);
		int total;
		int stop_at;
		int density;
		logic [7:0] pix;
		total = cur_w * cur_h;
		stop_at = cut ? $urandom_range(0, total - 1) : total;
		case ($urandom_range(0, 3))
			0: density = 50;
			1: density = 85;
			default: density = 97;
		endcase
		for (int i = 0; i < stop_at; i++) begin
			if (noisy && $urandom_range(0, 7) == 0) send(ACT_DRAIN, 8'($urandom), 1'b0);
			pix = ($urandom_range(1, 100) <= density) ? 8'($urandom_range(1, 255)) : PIX_CLEAR;
			send(ACT_PUSH, pix, counts);
		end
		if (!cut) begin
			for (int i = 0; i <= cur_w; i++)
				send((noisy && $urandom_range(0, 2) == 0) ? ACT_PUSH : ACT_DRAIN,
					8'($urandom), counts);
		end
	endtask

	// Receiver: random back-pressure, calm stretches, and one long hold-off.
	initial begin
		int hold;
		int left;
		bit calm;
		bit squeezed;
		left = 0;
		calm = 1'b0;
		squeezed = 1'b0;
		@(posedge clk);
		forever begin
			if (squeeze_req && !squeezed) begin
				squeezed = 1'b1;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				if (left == 0) begin
					calm = ($urandom_range(0, 3) == 0);
					left = $urandom_range(40, 300);
				end
				left--;
				if (!calm && $urandom_range(0, 2) == 0) begin
					hold = 1 + idle_len();
					m_tready <= 1'b0;
					repeat (hold) @(posedge clk);
				end
			end
			m_tready <= 1'b1;
			@(posedge clk);
		end
	end

	initial begin
		bit cut_prev;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// single-pixel frame; width 0 acts as 1, early drain is dropped
		configure(1'b1, 7'd0, 1'b1, 11'd1);
		send(ACT_DRAIN, 8'h5a, 1'b0);
		send(ACT_PUSH, 8'h80, 1'b0);
		send(ACT_DRAIN, 8'h00, 1'b0);
		send(ACT_DRAIN, 8'hff, 1'b0);

		// 3x3 all set: interior center, outline ring; a push past the end drains
		configure(1'b1, 7'd3, 1'b1, 11'd3);
		for (int i = 0; i < 8; i++) send(ACT_PUSH, 8'(1 << i), 1'b0);
		send(ACT_PUSH, 8'hff, 1'b0);
		send(ACT_PUSH, 8'h3c, 1'b0);
		repeat (3) send(ACT_DRAIN, 8'($urandom), 1'b0);

		// 2x2 with one lone set pixel among clear ones
		configure(1'b1, 7'd2, 1'b1, 11'd2);
		send(ACT_PUSH, PIX_CLEAR, 1'b0);
		send(ACT_PUSH, 8'hff, 1'b0);
		send(ACT_PUSH, PIX_CLEAR, 1'b0);
		send(ACT_PUSH, PIX_CLEAR, 1'b0);
		repeat (3) send(ACT_DRAIN, 8'($urandom), 1'b0);

		cut_prev = 1'b0;
		for (int n = 0; sent < ITEM_TARGET || n < 4; n++) begin
			steady = ($urandom_range(0, 3) == 0);
			if (n == 0) begin
				// widest frame, fed back to back while the receiver holds off
				steady = 1'b1;
				configure(1'b1, 7'd100, 1'b1, 11'd2);
				squeeze_req <= 1'b1;
				run_frame(1'b0, 1'b0, 1'b1);
				cut_prev = 1'b0;
			end else if (n == 3) begin
				// tallest frame at the narrowest width, then back to short frames
				configure(1'b1, 7'd1, 1'b1, 11'd2047);
				run_frame(1'b0, 1'b0, 1'b0);
				configure(1'b0, 7'd0, 1'b1, draw_height());
				cut_prev = 1'b0;
			end else begin
				if (cut_prev || $urandom_range(0, 9) < 7) begin
					case ($urandom_range(0, 2))
						0: configure(1'b1, draw_width(), 1'b0, 11'd0);
						1: configure(1'b0, 7'd0, 1'b1, draw_height());
						default: configure(1'b1, draw_width(), 1'b1, draw_height());
					endcase
				end
				cut_prev = ($urandom_range(0, 9) == 0);
				run_frame($urandom_range(0, 3) == 0, cut_prev, 1'b1);
			end
		end

		wait_idle();
		$display("Run covered %0d transactions (%0d random) across %0d register settings,",
			sent, counted, settings);
		$display("widths 1 to 64 and heights 1 to 1024; %0d results compared.", checked);
		if (errors == 0) begin
			$display("glyph_outline_3x3 verification clean");
		end else begin
			$display("glyph_outline_3x3 verification failed");
		end
		$finish;
	end

endmodule
